[rtl/psdf_pkg.sv]
// Shared constants and controller/datapath interface types for the padded
// signed decimal formatter. No dependencies.
package psdf_pkg;

    localparam int VALUE_W       = 64;
    localparam int MAX_WIDTH     = 32;
    localparam int DIGIT_CAP     = 20;
    localparam int BCD_W         = 4 * DIGIT_CAP;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
    localparam int CONV_W        = $clog2(CONV_STEPS);
    localparam int ND_W          = $clog2(DIGIT_CAP + 1);
    localparam int DI_W          = $clog2(DIGIT_CAP);
    // Length arithmetic must hold any 6-bit width setting as well as MAX_WIDTH
    localparam int LEN_W         = $clog2(((MAX_WIDTH > 63) ? MAX_WIDTH : 63) + 1);

    localparam int CFG_W         = 6;
    localparam int CFG_IDX_W     = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_FILL = 1'b1;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic count;
        logic emit_sign;
        logic emit_pad;
        logic emit_digit;
    } t_dp_cmd;

    typedef struct packed {
        logic neg;
        logic pads_zero;
        logic digit_last;
        logic out_free;
    } t_dp_status;

endpackage

[rtl/psdf_ctrl.sv]
// Sequencer for the formatter: load, binary-to-BCD conversion, digit count,
// then sign, pad and digit emission. Depends on psdf_pkg.
module psdf_ctrl import psdf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output logic       o_ready,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_COUNT = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_PAD   = 3'd4;
    localparam logic [2:0] ST_DIGIT = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [CONV_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.conv_step = 1'b1;
                n_step          = r_step + 1'b1;
                if (r_step == CONV_W'(CONV_STEPS - 1)) begin
                    n_state = ST_COUNT;
                end
            end
            ST_COUNT: begin
                o_cmd.count = 1'b1;
                n_state     = i_status.neg ? ST_SIGN : ST_PAD;
            end
            ST_SIGN: begin
                if (i_status.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = ST_PAD;
                end
            end
            ST_PAD: begin
                if (i_status.pads_zero) begin
                    n_state = ST_DIGIT;
                end else if (i_status.out_free) begin
                    o_cmd.emit_pad = 1'b1;
                end
            end
            ST_DIGIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_status.digit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

[rtl/psdf_dpath.sv]
// Datapath for the formatter: magnitude and BCD shift registers, pad and digit
// counters, and the output character register. Depends on psdf_pkg.
module psdf_dpath import psdf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [CFG_W-1:0]   i_min_width,
    input  logic               i_zero_fill,
    input  logic               i_out_ready,
    output t_dp_status         o_status,
    output logic [7:0]         o_char,
    output logic               o_last,
    output logic               o_valid
);

    logic [VALUE_W-1:0] r_mag, n_mag;
    logic [BCD_W-1:0]   r_bcd, n_bcd;
    logic               r_neg;
    logic [LEN_W-1:0]   r_pads;
    logic [DI_W-1:0]    r_di;
    logic [7:0]         r_char;
    logic               r_last;
    logic               r_valid;

    logic [ND_W-1:0]    w_nd;
    logic [LEN_W-1:0]   w_width;
    logic [LEN_W-1:0]   w_textlen;
    logic [LEN_W-1:0]   w_pads;
    logic               w_out_free;
    logic [3:0]         w_digit;

    // Double dabble, four magnitude bits per cycle
    always_comb begin
        logic [BCD_W-1:0]   v_bcd;
        logic [VALUE_W-1:0] v_mag;
        v_bcd = r_bcd;
        v_mag = r_mag;
        for (int s = 0; s < BITS_PER_STEP; s++) begin
            for (int d = 0; d < DIGIT_CAP; d++) begin
                if (v_bcd[4*d +: 4] >= 4'd5) begin
                    v_bcd[4*d +: 4] = v_bcd[4*d +: 4] + 4'd3;
                end
            end
            v_bcd = {v_bcd[BCD_W-2:0], v_mag[VALUE_W-1]};
            v_mag = {v_mag[VALUE_W-2:0], 1'b0};
        end
        n_bcd = v_bcd;
        n_mag = v_mag;
    end

    // Significant digit count, at least one so zero prints as a single digit
    always_comb begin
        logic [ND_W-1:0] v_nd;
        v_nd = ND_W'(1);
        for (int d = 0; d < DIGIT_CAP; d++) begin
            if (r_bcd[4*d +: 4] != 4'd0) begin
                v_nd = ND_W'(d + 1);
            end
        end
        w_nd = v_nd;
    end

    assign w_width   = (LEN_W'(i_min_width) > LEN_W'(MAX_WIDTH)) ? LEN_W'(MAX_WIDTH)
                                                                 : LEN_W'(i_min_width);
    assign w_textlen = LEN_W'(w_nd) + LEN_W'(r_neg);
    assign w_pads    = (w_width > w_textlen) ? (w_width - w_textlen) : '0;

    assign w_out_free = !r_valid || i_out_ready;
    assign w_digit    = r_bcd[4*r_di +: 4];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= i_value[VALUE_W-1];
            r_mag <= i_value[VALUE_W-1] ? (~i_value + 1'b1) : i_value;
            r_bcd <= '0;
        end else if (i_cmd.conv_step) begin
            r_mag <= n_mag;
            r_bcd <= n_bcd;
        end
        if (i_cmd.count) begin
            r_pads <= w_pads;
            r_di   <= DI_W'(w_nd - 1'b1);
        end else if (i_cmd.emit_pad) begin
            r_pads <= r_pads - 1'b1;
        end else if (i_cmd.emit_digit) begin
            r_di <= r_di - 1'b1;
        end
        // Output character register; loaded only when the slot is free
        if (i_cmd.emit_sign) begin
            r_char <= CHAR_MINUS;
            r_last <= 1'b0;
        end else if (i_cmd.emit_pad) begin
            r_char <= i_zero_fill ? CHAR_ZERO : CHAR_SPACE;
            r_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_char <= CHAR_ZERO + {4'd0, w_digit};
            r_last <= (r_di == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_pad || i_cmd.emit_digit) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_status.neg        = r_neg;
    assign o_status.pads_zero  = (r_pads == '0);
    assign o_status.digit_last = (r_di == '0);
    assign o_status.out_free   = w_out_free;

    assign o_char  = r_char;
    assign o_last  = r_last;
    assign o_valid = r_valid;

`ifndef ASSERT_OFF
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_sign || i_cmd.emit_pad || i_cmd.emit_digit) |-> w_out_free)
        else $error("character emitted into an occupied output register");

    a_conv_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.count |-> (r_mag == '0))
        else $error("digit count started before all magnitude bits were shifted");

    a_last_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> (r_char >= CHAR_ZERO && r_char <= CHAR_NINE))
        else $error("final character of a value is not a digit");
`endif

endmodule

[rtl/padded_signed_decimal_formatter_unit.sv]
// Padded signed decimal formatter: turns a signed 64-bit value into an ASCII
// character stream. Each accepted value is loaded, converted from binary to
// BCD at four bits per cycle and has its significant digits counted; then its
// sign, pads and digits are emitted, each only when the output register is
// free, and the pad phase ends in a step that emits nothing. The character
// count is sign plus digits, raised to min_width (capped at 32). A new value is
// taken only after the last character of the previous one has gone to the
// output register. Registers: index 0 min_width, index 1 pad select
// (1 zero, 0 space). Depends on psdf_pkg, psdf_ctrl and psdf_dpath.
module padded_signed_decimal_formatter_unit import psdf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [VALUE_W-1:0]   i_s_tdata,   // [63:0] value (signed)
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [7:0]           o_m_tdata,   // [7:0] char_code
    output logic                 o_m_tlast,   // is_last
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0] r_min_width;
    logic             r_zero_fill;
    t_dp_cmd          w_cmd;
    t_dp_status       w_status;
    logic             w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_width <= '0;
            r_zero_fill <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_WIDTH: r_min_width <= i_cfg_data;
                CFG_ZERO_FILL: r_zero_fill <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    psdf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_s_tvalid),
        .i_status (w_status),
        .o_ready  (w_ready),
        .o_cmd    (w_cmd)
    );

    psdf_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_value     (i_s_tdata),
        .i_min_width (r_min_width),
        .i_zero_fill (r_zero_fill),
        .i_out_ready (i_m_tready),
        .o_status    (w_status),
        .o_char      (o_m_tdata),
        .o_last      (o_m_tlast),
        .o_valid     (o_m_tvalid)
    );

    assign o_s_tready = w_ready;

endmodule
